// ----- rtl/core/ofifo_pkg.sv -----
// ----------------------------------------------------------------------------
// ofifo_pkg
// Shared types and codes for the overwriting ring FIFO.
// ----------------------------------------------------------------------------
package ofifo_pkg;

    localparam int WORD_W = 32;
    localparam int FLD_W  = 5;

    // input mode codes
    localparam logic [1:0] MODE_SEND   = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_VIEW   = 2'd2;

    // result kind codes
    localparam logic [1:0] KIND_ADDED   = 2'd0;
    localparam logic [1:0] KIND_REMOVED = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;
    localparam logic [1:0] KIND_LISTED  = 2'd3;

    typedef enum logic [1:0] {
        OP_SEND,
        OP_DELETE,
        OP_VIEW
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] payload;
    } cmd_t;

    // queue status seen by the front end
    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

    // result fields carried alongside the memory read
    typedef struct packed {
        logic [1:0]       kind;
        logic             evicted;
        logic [FLD_W-1:0] position;
        logic [FLD_W-1:0] occupancy;
        logic             last;
        logic             use_data;
    } meta_t;

endpackage

// ----- rtl/core/overwrite_ring_fifo.sv -----
// Results pass the command queue, the ring read/meta registers and the output
// register. One send or delete per cycle unless the result side stalls; a view
// holds the back end until every entry is listed, one ring memory read per entry.
// Reset clears head, fill count and all valid flags; ring contents are not reset.
// ----------------------------------------------------------------------------
// overwrite_ring_fifo
// Circular FIFO that overwrites its oldest entry when full.
// ----------------------------------------------------------------------------
module overwrite_ring_fifo #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] payload,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [31:0] data_word,
    output logic        evicted,
    output logic [4:0]  position,
    output logic [4:0]  occupancy,
    output logic        last
);
    import ofifo_pkg::*;

    q_status_t q_status;
    cmd_t      push_cmd;
    cmd_t      head_cmd;
    logic      push;
    logic      pop;

    ofifo_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .payload  (payload),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    ofifo_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_status (q_status)
    );

    ofifo_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_status.valid),
        .q_cmd     (head_cmd),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .data_word (data_word),
        .evicted   (evicted),
        .position  (position),
        .occupancy (occupancy),
        .last      (last)
    );

endmodule

// ----- rtl/core/ofifo_front.sv -----
// ----------------------------------------------------------------------------
// ofifo_front
// Input side: takes transfers, decodes the mode and pushes commands.
// ----------------------------------------------------------------------------
module ofifo_front (
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              mode,
    input  logic [31:0]             payload,
    input  ofifo_pkg::q_status_t    q_status,
    output logic                    push,
    output ofifo_pkg::cmd_t         push_cmd
);
    import ofifo_pkg::*;

    logic known_mode;

    assign in_stall = q_status.full;

    always_comb
    begin
        known_mode       = 1'b1;
        push_cmd.op      = OP_SEND;
        push_cmd.payload = payload;
        case (mode)
            MODE_SEND:   push_cmd.op = OP_SEND;
            MODE_DELETE: push_cmd.op = OP_DELETE;
            MODE_VIEW:   push_cmd.op = OP_VIEW;
            default:     known_mode  = 1'b0;   // unused code: taken and dropped
        endcase
    end

    assign push = in_valid && !q_status.full && known_mode;

endmodule

// ----- rtl/core/ofifo_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// ofifo_cmd_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module ofifo_cmd_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ofifo_pkg::cmd_t         push_cmd,
    input  logic                    pop,
    output ofifo_pkg::cmd_t         head_cmd,
    output ofifo_pkg::q_status_t    q_status
);
    import ofifo_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_pop;

    assign do_pop         = pop && (cnt_reg != 2'd0);
    assign head_cmd       = slot_reg[rd_ptr_reg];
    assign q_status.valid = (cnt_reg != 2'd0);
    assign q_status.full  = (cnt_reg == 2'd2);

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/core/ofifo_back.sv -----
// ----------------------------------------------------------------------------
// ofifo_back
// Execution side: ring memory, head and fill count, view walk, output register.
// ----------------------------------------------------------------------------
module ofifo_back #(
    parameter int DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  ofifo_pkg::cmd_t      q_cmd,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           kind,
    output logic [31:0]          data_word,
    output logic                 evicted,
    output logic [4:0]           position,
    output logic [4:0]           occupancy,
    output logic                 last
);
    import ofifo_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [WORD_W-1:0] mem [DEPTH];

    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [AW-1:0]     idx_reg;
    logic [AW-1:0]     idx_next;
    logic [WORD_W-1:0] rd_reg;
    meta_t             meta_reg;
    meta_t             meta_next;
    logic              b_valid_reg;
    logic              b_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [1:0]        kind_reg;
    logic [WORD_W-1:0] data_reg;
    logic              evicted_reg;
    logic [FLD_W-1:0]  position_reg;
    logic [FLD_W-1:0]  occupancy_reg;
    logic              last_reg;

    logic              issue;
    logic              b_adv;
    logic              rd_en;
    logic              wr_en;
    logic [AW-1:0]     raddr;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     head_inc;
    logic [CW-1:0]     count_inc;
    logic [CW-1:0]     count_dec;
    logic [CW-1:0]     view_pos;
    logic              is_full;
    logic              is_empty;

    function automatic logic [AW-1:0] wrap_addr(input logic [AW:0] s);
        logic [AW:0] t;
        begin
            t = (s >= DEPTH_A) ? (s - DEPTH_A) : s;
            return t[AW-1:0];
        end
    endfunction

    assign b_adv = b_valid_reg && (!out_valid_reg || !out_stall);
    assign issue = q_valid && (!b_valid_reg || b_adv);

    assign is_full   = (count_reg == DEPTH_C);
    assign is_empty  = (count_reg == '0);
    assign head_inc  = wrap_addr({1'b0, head_reg} + (AW + 1)'(1));
    assign count_inc = count_reg + CW'(1);
    assign count_dec = count_reg - CW'(1);
    assign view_pos  = CW'(idx_reg) + CW'(1);

    always_comb
    begin
        head_next           = head_reg;
        count_next          = count_reg;
        idx_next            = idx_reg;
        q_pop               = 1'b0;
        rd_en               = 1'b0;
        wr_en               = 1'b0;
        raddr               = head_reg;
        waddr               = head_reg;
        meta_next.kind      = KIND_EMPTY;
        meta_next.evicted   = 1'b0;
        meta_next.position  = '0;
        meta_next.occupancy = FLD_W'(count_reg);
        meta_next.last      = 1'b1;
        meta_next.use_data  = 1'b0;

        if (issue)
        begin
            case (q_cmd.op)
                OP_SEND:
                begin
                    q_pop          = 1'b1;
                    wr_en          = 1'b1;
                    meta_next.kind = KIND_ADDED;
                    if (is_full)
                    begin
                        // oldest slot is read and overwritten in the same cycle
                        rd_en              = 1'b1;
                        head_next          = head_inc;
                        meta_next.evicted  = 1'b1;
                        meta_next.use_data = 1'b1;
                    end
                    else
                    begin
                        waddr = wrap_addr({1'b0, head_reg} + (AW + 1)'(count_reg));
                        count_next          = count_inc;
                        meta_next.occupancy = FLD_W'(count_inc);
                    end
                end
                OP_DELETE:
                begin
                    q_pop = 1'b1;
                    if (!is_empty)
                    begin
                        rd_en               = 1'b1;
                        head_next           = head_inc;
                        count_next          = count_dec;
                        meta_next.kind      = KIND_REMOVED;
                        meta_next.occupancy = FLD_W'(count_dec);
                        meta_next.use_data  = 1'b1;
                    end
                end
                OP_VIEW:
                begin
                    if (is_empty)
                    begin
                        q_pop = 1'b1;
                    end
                    else
                    begin
                        rd_en              = 1'b1;
                        raddr              = wrap_addr({1'b0, head_reg} + {1'b0, idx_reg});
                        meta_next.kind     = KIND_LISTED;
                        meta_next.position = FLD_W'(view_pos);
                        meta_next.use_data = 1'b1;
                        meta_next.last     = (view_pos == count_reg);
                        if (view_pos == count_reg)
                        begin
                            q_pop    = 1'b1;
                            idx_next = '0;
                        end
                        else
                        begin
                            idx_next = idx_reg + AW'(1);
                        end
                    end
                end
                default:
                begin
                    q_pop = 1'b1;
                end
            endcase
        end

        if (issue)
            b_valid_next = 1'b1;
        else if (b_adv)
            b_valid_next = 1'b0;
        else
            b_valid_next = b_valid_reg;

        if (b_adv)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ring memory, read-first
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= q_cmd.payload;
        end
        if (rd_en)
        begin
            rd_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            meta_reg <= meta_next;
        end
        if (b_adv)
        begin
            kind_reg      <= meta_reg.kind;
            data_reg      <= meta_reg.use_data ? rd_reg : '0;
            evicted_reg   <= meta_reg.evicted;
            position_reg  <= meta_reg.position;
            occupancy_reg <= meta_reg.occupancy;
            last_reg      <= meta_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign data_word = data_reg;
    assign evicted   = evicted_reg;
    assign position  = position_reg;
    assign occupancy = occupancy_reg;
    assign last      = last_reg;

endmodule

// ----- rtl/core/ofifo_checker.sv -----
// ----------------------------------------------------------------------------
// ofifo_checker
// Port-level checks for the overwriting ring FIFO.
// ----------------------------------------------------------------------------
module ofifo_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  mode,
    input logic [31:0] payload,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [31:0] data_word,
    input logic        evicted,
    input logic [4:0]  position,
    input logic [4:0]  occupancy,
    input logic        last
);
    import ofifo_pkg::*;

    // a stalled input transfer holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(mode) && $stable(payload))
        else $error("input changed while stalled");

    // a stalled result transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_word)
            && $stable(last) && $stable(occupancy))
        else $error("result changed while stalled");

    // a plain add carries no word
    a_add_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_ADDED) && !evicted |-> (data_word == '0))
        else $error("add without eviction carries data");

    // empty result is a single final transfer with nothing held
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_EMPTY) |-> last && (occupancy == '0)
            && (data_word == '0) && (position == '0))
        else $error("malformed empty result");

    // only a send can evict
    a_evict_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> (kind == KIND_ADDED) && last)
        else $error("eviction flag on non-send result");

endmodule

bind overwrite_ring_fifo ofifo_checker u_ofifo_checker (.*);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the overwriting ring FIFO. Sends, deletes, views
// and ignored codes are driven with random idle gaps on the input side and
// random stalls on the result side. A scoreboard model of the ring predicts
// every result, and each result transfer is checked in order.
// ----------------------------------------------------------------------------
module tb_top;

    import ofifo_pkg::*;

    localparam int          RING_DEPTH   = 16;
    localparam int          RANDOM_ITEMS = 500;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          MAX_REPORTS  = 10;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] data_word;
        logic        evicted;
        logic [4:0]  position;
        logic [4:0]  occupancy;
        logic        is_last;
    } fifo_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [1:0]  mode      = MODE_SEND;
    logic [31:0] payload   = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [31:0] data_word;
    logic        evicted;
    logic [4:0]  position;
    logic [4:0]  occupancy;
    logic        last;

    // scoreboard copy of the ring
    logic [31:0] ring_mem [RING_DEPTH];
    int          ring_head = 0;
    int          ring_fill = 0;

    fifo_result_t expected_results [$];

    bit          idle_en = 1'b1;
    int          err_cnt = 0;
    int          results_checked = 0;
    int          n_sends = 0;
    int          n_deletes = 0;
    int          n_views = 0;
    int          n_ignored = 0;
    int          n_evictions = 0;
    int          n_empty = 0;
    int unsigned cycle_cnt = 0;

    overwrite_ring_fifo #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .payload   (payload),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .data_word (data_word),
        .evicted   (evicted),
        .position  (position),
        .occupancy (occupancy),
        .last      (last)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Scoreboard update for one accepted operation
    task automatic predict_op(input logic [1:0] m, input logic [31:0] w);
        fifo_result_t r;
        int           i;
        r = '{kind: KIND_ADDED, data_word: 32'd0, evicted: 1'b0,
              position: 5'd0, occupancy: 5'd0, is_last: 1'b1};
        case (m)
            MODE_SEND:
            begin
                n_sends++;
                if (ring_fill == RING_DEPTH)
                begin
                    r.data_word = ring_mem[ring_head];
                    r.evicted   = 1'b1;
                    ring_head   = (ring_head + 1) % RING_DEPTH;
                    ring_fill--;
                    n_evictions++;
                end
                ring_mem[(ring_head + ring_fill) % RING_DEPTH] = w;
                ring_fill++;
                r.occupancy = 5'(ring_fill);
                expected_results.push_back(r);
            end
            MODE_DELETE:
            begin
                n_deletes++;
                if (ring_fill == 0)
                begin
                    r.kind = KIND_EMPTY;
                    n_empty++;
                end
                else
                begin
                    r.kind      = KIND_REMOVED;
                    r.data_word = ring_mem[ring_head];
                    ring_head   = (ring_head + 1) % RING_DEPTH;
                    ring_fill--;
                    r.occupancy = 5'(ring_fill);
                end
                expected_results.push_back(r);
            end
            MODE_VIEW:
            begin
                n_views++;
                if (ring_fill == 0)
                begin
                    r.kind = KIND_EMPTY;
                    n_empty++;
                    expected_results.push_back(r);
                end
                else
                begin
                    for (i = 0; i < ring_fill; i++)
                    begin
                        r.kind      = KIND_LISTED;
                        r.data_word = ring_mem[(ring_head + i) % RING_DEPTH];
                        r.position  = 5'(i + 1);
                        r.occupancy = 5'(ring_fill);
                        r.is_last   = (i + 1 == ring_fill);
                        expected_results.push_back(r);
                    end
                end
            end
            default:
                n_ignored++;
        endcase
    endtask

    // One input transfer, preceded by a random idle gap while gaps are enabled
    task automatic push_op(input logic [1:0] m, input logic [31:0] w);
        int gap;
        gap = idle_en ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        payload  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_op(m, w);
    endtask

    // Hold the sender off until every predicted result has been seen
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // Result side: random stall before each transfer while stalls are enabled
    initial
    begin : result_sink
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = idle_en ? $urandom_range(0, 10) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        fifo_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            results_checked++;
            if (expected_results.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("unexpected result: kind %0d word %h", kind, data_word);
            end
            else
            begin
                want = expected_results.pop_front();
                if (kind !== want.kind || data_word !== want.data_word ||
                    evicted !== want.evicted || position !== want.position ||
                    occupancy !== want.occupancy || last !== want.is_last)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                    begin
                        $display("mismatch exp: kind %0d word %h ev %0d pos %0d occ %0d last %0d",
                                 want.kind, want.data_word, want.evicted,
                                 want.position, want.occupancy, want.is_last);
                        $display("         got: kind %0d word %h ev %0d pos %0d occ %0d last %0d",
                                 kind, data_word, evicted, position, occupancy, last);
                    end
                end
            end
        end
    end

    // Empty ring: delete and view both report empty, unused code ignored
    task automatic test_empty_ring();
        idle_en = 1'b1;
        push_op(MODE_DELETE, 32'hFFFF_FFFF);
        push_op(MODE_VIEW, 32'h0000_0000);
        push_op(MODE_UNUSED, 32'hA5A5_A5A5);
    endtask

    // Fill to capacity back to back, list it, overwrite, pop, list again
    task automatic test_fill_and_overwrite();
        int i;
        idle_en = 1'b0;
        push_op(MODE_SEND, 32'h0000_0000);
        push_op(MODE_SEND, 32'hFFFF_FFFF);
        push_op(MODE_SEND, 32'h8000_0000);
        push_op(MODE_SEND, 32'h0000_0001);
        for (i = 4; i < RING_DEPTH; i++)
            push_op(MODE_SEND, $urandom);
        push_op(MODE_VIEW, $urandom);
        push_op(MODE_SEND, 32'h5555_AAAA);  // full: oldest word evicted
        push_op(MODE_DELETE, $urandom);
        push_op(MODE_UNUSED, $urandom);
        push_op(MODE_VIEW, $urandom);
    endtask

    // Random mix in phases biased towards filling, draining or neither
    task automatic test_random_traffic();
        int          done;
        int          pick;
        int          send_pct;
        int          del_pct;
        logic [1:0]  m;
        logic [31:0] w;
        done     = 0;
        send_pct = 40;
        del_pct  = 35;
        while (done < RANDOM_ITEMS)
        begin
            if (done % 50 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       begin send_pct = 70; del_pct = 10; end
                    1:       begin send_pct = 20; del_pct = 60; end
                    default: begin send_pct = 40; del_pct = 35; end
                endcase
                idle_en = ((done / 50) % 4 != 1);
            end
            if (done % 120 == 60)
                wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < send_pct)
                m = MODE_SEND;
            else if (pick < send_pct + del_pct)
                m = MODE_DELETE;
            else if (pick < 95)
                m = MODE_VIEW;
            else
                m = MODE_UNUSED;
            case ($urandom_range(0, 7))
                0:       w = 32'h0000_0000;
                1:       w = 32'hFFFF_FFFF;
                default: w = $urandom;
            endcase
            push_op(m, w);
            if (m != MODE_UNUSED)
                done++;
        end
    endtask

    // List and pop everything left, then delete and view once more on the empty ring
    task automatic test_drain_to_empty();
        idle_en = 1'b1;
        wait_drained();
        push_op(MODE_VIEW, $urandom);
        while (ring_fill > 0)
            push_op(MODE_DELETE, $urandom);
        push_op(MODE_DELETE, $urandom);
        push_op(MODE_VIEW, $urandom);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_ring();
        test_fill_and_overwrite();
        test_random_traffic();
        test_drain_to_empty();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("ops: %0d send (%0d evicting), %0d delete, %0d view, %0d ignored",
                 n_sends, n_evictions, n_deletes, n_views, n_ignored);
        $display("%0d results checked, %0d empty reports, %0d errors",
                 results_checked, n_empty, err_cnt);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
